### rtl/rtpss_pkg.sv
// ----------------------------------------------------------------------------
// rtpss_pkg
// Types and constants shared by the RTP stream statistics table.
// ----------------------------------------------------------------------------
package rtpss_pkg;

  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned PT_W     = 7;
  localparam int unsigned CLASS_W  = 2;
  localparam int unsigned JIT_W    = 36;

  // fixed protocol constants
  localparam logic [15:0] HDR_LEN   = 16'd12;
  localparam logic [7:0]  PT_MASK   = 8'h7F;
  localparam logic [5:0]  JIT_ROUND = 6'd8;
  localparam int unsigned JIT_SHIFT = 4;

  // payload types with a codec class of their own
  localparam logic [PT_W-1:0] PT_PCMU = 7'd0;
  localparam logic [PT_W-1:0] PT_PCMA = 7'd8;
  localparam logic [PT_W-1:0] PT_G729 = 7'd18;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_PCMU  = 2'd0,
    CLASS_PCMA  = 2'd1,
    CLASS_G729  = 2'd2,
    CLASS_OTHER = 2'd3
  } codec_class_e;

  typedef enum logic {
    OP_PACKET = 1'b0,
    OP_CLEAR  = 1'b1
  } operation_e;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_e;

  typedef struct packed {
    logic              operation;
    logic [SLOT_W-1:0] session_slot;
    logic [7:0]        type_byte;
    logic [15:0]       sequence_number;
    logic [31:0]       media_timestamp;
    logic [15:0]       packet_length;
    logic [31:0]       arrival_time;
  } in_t;

  typedef struct packed {
    logic [31:0]        packet_count;
    logic [47:0]        byte_count;
    logic [31:0]        lost_count;
    logic [JIT_W-1:0]   jitter_scaled;
    logic [PT_W-1:0]    payload_kind;
    logic [CLASS_W-1:0] codec_class;
    logic [31:0]        first_seen_time;
    logic [31:0]        last_seen_time;
  } out_t;

  // one slot of the statistics memory
  typedef struct packed {
    logic [31:0]      packets;
    logic [47:0]      bytes_total;
    logic [31:0]      losses;
    logic [15:0]      previous_sequence;
    logic [31:0]      previous_media_time;
    logic [JIT_W-1:0] jitter_estimate;
    logic [PT_W-1:0]  codec_type;
    logic [31:0]      first_time;
    logic [31:0]      latest_time;
  } entry_t;

  // map a payload type onto its codec class
  function automatic logic [CLASS_W-1:0] class_of(input logic [PT_W-1:0] pt);
    logic [CLASS_W-1:0] cls;
    case (pt)
      PT_PCMU: cls = CLASS_PCMU;
      PT_PCMA: cls = CLASS_PCMA;
      PT_G729: cls = CLASS_G729;
      default: cls = CLASS_OTHER;
    endcase
    return cls;
  endfunction

endpackage

### rtl/rtpss_update.sv
// ----------------------------------------------------------------------------
// rtpss_update
// Modify step of the slot read-modify-write: counters, loss, jitter, times.
// ----------------------------------------------------------------------------
module rtpss_update
  import rtpss_pkg::*;
(
  input  in_t    item_i,
  input  entry_t old_i,
  input  logic   seen_i,
  input  logic   in_range_i,
  output entry_t entry_o,
  output logic   seen_o,
  output out_t   result_o
);

  entry_t            pkt;
  logic [32:0]       pkt_sum;
  logic [15:0]       pay_len;
  logic [48:0]       byte_sum;
  logic [16:0]       prev_next;
  logic [15:0]       gap;
  logic [32:0]       loss_sum;
  logic [31:0]       ts_diff;
  logic [JIT_W:0]    jit_round;
  logic [JIT_W+1:0]  jit_sum;

  // saturating packet and byte counters
  assign pkt_sum  = {1'b0, old_i.packets} + 33'd1;
  assign pay_len  = item_i.packet_length - HDR_LEN;
  assign byte_sum = {1'b0, old_i.bytes_total} + {33'd0, pay_len};

  // forward sequence gap, plain difference without wrap
  assign prev_next = {1'b0, old_i.previous_sequence} + 17'd1;
  assign gap       = item_i.sequence_number - old_i.previous_sequence - 16'd1;
  assign loss_sum  = {1'b0, old_i.losses} + {17'd0, gap};

  // jitter: J + d - ((J + 8) >> 4), clamped to the field width
  assign ts_diff   = (item_i.media_timestamp >= old_i.previous_media_time)
                   ? item_i.media_timestamp - old_i.previous_media_time
                   : old_i.previous_media_time - item_i.media_timestamp;
  assign jit_round = ({1'b0, old_i.jitter_estimate} + {{(JIT_W-5){1'b0}}, JIT_ROUND})
                     >> JIT_SHIFT;
  assign jit_sum   = {2'b00, old_i.jitter_estimate} + {{(JIT_W-30){1'b0}}, ts_diff}
                   - {1'b0, jit_round};

  // entry after one packet
  always_comb begin
    pkt = old_i;
    pkt.packets = pkt_sum[32] ? '1 : pkt_sum[31:0];
    if (item_i.packet_length > HDR_LEN) begin
      pkt.bytes_total = byte_sum[48] ? '1 : byte_sum[47:0];
    end
    if (!seen_i) begin
      pkt.first_time = item_i.arrival_time;
    end else begin
      if ({1'b0, item_i.sequence_number} > prev_next) begin
        pkt.losses = loss_sum[32] ? '1 : loss_sum[31:0];
      end
      pkt.jitter_estimate = (jit_sum[JIT_W+1:JIT_W] != 2'b00) ? '1 : jit_sum[JIT_W-1:0];
    end
    pkt.latest_time         = item_i.arrival_time;
    pkt.previous_sequence   = item_i.sequence_number;
    pkt.previous_media_time = item_i.media_timestamp;
    pkt.codec_type          = PT_W'(item_i.type_byte & PT_MASK);
  end

  // choose packet or clear, and build the result beat
  always_comb begin
    if (item_i.operation == OP_CLEAR) begin
      entry_o = '0;
      seen_o  = 1'b0;
    end else begin
      entry_o = pkt;
      seen_o  = 1'b1;
    end
    result_o = '0;
    if (in_range_i) begin
      result_o.packet_count    = entry_o.packets;
      result_o.byte_count      = entry_o.bytes_total;
      result_o.lost_count      = entry_o.losses;
      result_o.jitter_scaled   = entry_o.jitter_estimate;
      result_o.payload_kind    = entry_o.codec_type;
      result_o.codec_class     = class_of(entry_o.codec_type);
      result_o.first_seen_time = entry_o.first_time;
      result_o.last_seen_time  = entry_o.latest_time;
    end
  end

endmodule

### rtl/rtp_stream_statistics_table_core.sv
// ----------------------------------------------------------------------------
// rtp_stream_statistics_table_core
// Per-session RTP receiver statistics held in one slot memory.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low: the slot's memory
// entry is read on the accepting edge, and the modified entry is written
// back on the next edge while busy is high. The result is registered on
// result_o and marked by done_o for exactly one cycle, and cannot be held
// off by the receiver; the next item may be started in that same cycle.
// While busy is high no new item is taken, as the read-modify-write of the
// single-port slot memory must finish first. The seen flag of each
// slot lives in flip-flops that reset clears at once; a slot whose flag is
// clear reads as all zero, so no clearing pass follows reset. Slots at or
// above SESSIONS return an all-zero result and change nothing.
module rtp_stream_statistics_table_core
  import rtpss_pkg::*;
#(
  parameter int unsigned SESSIONS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  in_i,
  output logic done_o,
  output out_t result_o
);

  localparam int unsigned AW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int unsigned IW = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int unsigned CW = IW + 1;

  state_e             state_q, state_d;
  in_t                item_q;
  logic [AW-1:0]      idx_q;
  logic               in_range_q;
  logic               seen_rd_q;
  entry_t             rd_q;
  logic [SESSIONS-1:0] seen_q;
  entry_t             mem [SESSIONS];

  logic [IW-1:0]      slot_ext;
  logic [AW-1:0]      idx;
  logic               in_range;
  logic               accept;
  entry_t             old_entry;
  entry_t             new_entry;
  logic               new_seen;
  out_t               result;
  logic               wr_en;

  assign slot_ext = IW'(in_i.session_slot);
  assign idx      = slot_ext[AW-1:0];
  assign in_range = CW'(in_i.session_slot) < CW'(SESSIONS);
  assign accept   = start && (state_q == ST_IDLE);
  assign busy     = (state_q != ST_IDLE);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and write enable
  always_comb begin
    state_d = state_q;
    wr_en   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        wr_en   = in_range_q;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // capture the beat on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q     <= in_i;
      idx_q      <= idx;
      in_range_q <= in_range;
      seen_rd_q  <= in_range ? seen_q[idx] : 1'b0;
    end
  end

  // slot memory: registered read on accept, write back in the modify cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem[idx];
    end
    if (wr_en) begin
      mem[idx_q] <= new_entry;
    end
  end

  // seen flags double as the entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (wr_en) begin
      seen_q[idx_q] <= new_seen;
    end
  end

  // a slot never written since reset or clear reads as zero
  assign old_entry = seen_rd_q ? rd_q : '0;

  rtpss_update u_update (
    .item_i     (item_q),
    .old_i      (old_entry),
    .seen_i     (seen_rd_q),
    .in_range_i (in_range_q),
    .entry_o    (new_entry),
    .seen_o     (new_seen),
    .result_o   (result)
  );

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= (state_q == ST_CALC);
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) begin
      result_o <= result;
    end
  end

endmodule
